// ----- hw/rtl/tga_pkg.sv -----
// tga_pkg: shared types and constants for the tga rle image decoder
// no dependencies; used by the channel interfaces and the top level

package tga_pkg;

    localparam logic [2:0] ST_PIXEL_RUN = 3'd0;
    localparam logic [2:0] ST_HEADER_OK = 3'd1;
    localparam logic [2:0] ST_COLOR_MAP = 3'd2;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd3;
    localparam logic [2:0] ST_BAD_DEPTH = 3'd4;
    localparam logic [2:0] ST_BAD_ALPHA = 3'd5;
    localparam logic [2:0] ST_GREYSCALE = 3'd6;

    localparam logic [4:0] HDR_ID_LEN   = 5'd0;
    localparam logic [4:0] HDR_MAP_TYPE = 5'd1;
    localparam logic [4:0] HDR_IMG_TYPE = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_DEPTH    = 5'd16;
    localparam logic [4:0] HDR_DESC     = 5'd17;

    localparam logic [7:0] MAP_PRESENT   = 8'd1;
    localparam logic [7:0] TYPE_TRUE_RAW = 8'd2;
    localparam logic [7:0] TYPE_GREY_RAW = 8'd3;
    localparam logic [7:0] TYPE_TRUE_RLE = 8'd10;
    localparam logic [7:0] TYPE_GREY_RLE = 8'd11;

    localparam logic [7:0] DEPTH_8  = 8'd8;
    localparam logic [7:0] DEPTH_16 = 8'd16;
    localparam logic [7:0] DEPTH_24 = 8'd24;
    localparam logic [7:0] DEPTH_32 = 8'd32;

    localparam logic [3:0] ALPHA_NONE  = 4'd0;
    localparam logic [3:0] ALPHA_EIGHT = 4'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] pixel_value;
        logic [7:0]  run_length;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [2:0]  bytes_per_pixel;
        logic        last_pixel;
    } t_out_item;

endpackage

// ----- hw/rtl/tga_in_if.sv -----
// tga_in_if: byte input channel, valid/ready with one file byte per transfer
// depends on tga_pkg

interface tga_in_if;
    logic               valid;
    logic               ready;
    tga_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/tga_out_if.sv -----
// tga_out_if: result channel, valid/ready with one status or pixel run per transfer
// depends on tga_pkg

interface tga_out_if;
    logic               valid;
    logic               ready;
    tga_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/tga_rle_image_decoder.sv -----
// tga_rle_image_decoder: byte-serial tga header parser and raw/rle truecolor decoder
// depends on tga_pkg, tga_in_if, tga_out_if
// each byte is registered in the input register, and its result in the output register
// throughput: one byte per cycle while the result side keeps up
// a byte sits in the input register, one pass of logic updates the parse state
// reset (synchronous, active low) empties both registers and returns to the header

module tga_rle_image_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tga_in_if.sink    i_in,
    tga_out_if.source o_out
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_IDSKIP,
        PH_PACKET,
        PH_PIXEL,
        PH_DONE,
        PH_ERROR
    } t_phase;

    logic              r_in_valid;
    tga_pkg::t_in_item r_in_data;
    logic               r_out_valid;
    tga_pkg::t_out_item r_out_data;

    t_phase      r_phase,    n_phase;
    logic [4:0]  r_hdr_idx,  n_hdr_idx;
    logic [7:0]  r_id_left,  n_id_left;
    logic        r_rle,      n_rle;
    logic        r_grey,     n_grey;
    logic [15:0] r_width,    n_width;
    logic [15:0] r_height,   n_height;
    logic [2:0]  r_pix_size, n_pix_size;
    logic [31:0] r_pix_left, n_pix_left;
    logic [7:0]  r_pkt_left, n_pkt_left;
    logic        r_pkt_run,  n_pkt_run;
    logic [31:0] r_asm,      n_asm;
    logic [1:0]  r_byte_idx, n_byte_idx;

    logic               n_emit;
    tga_pkg::t_out_item n_out;

    logic advance;
    logic in_ready;

    // working copies of state after a start of file
    t_phase      e_phase;
    logic [4:0]  e_hdr_idx;
    logic [7:0]  e_id_left;
    logic        e_rle;
    logic        e_grey;
    logic [15:0] e_width;
    logic [15:0] e_height;
    logic [2:0]  e_pix_size;
    logic [31:0] e_pix_left;
    logic [7:0]  e_pkt_left;
    logic        e_pkt_run;
    logic [31:0] e_asm;
    logic [1:0]  e_byte_idx;

    logic [7:0]  b;
    logic [31:0] area;
    logic [31:0] asm_next;
    logic [31:0] pix_val;
    logic [7:0]  run;
    logic [31:0] left_after;
    logic [7:0]  pkt_after;

    assign advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_ready = !r_in_valid || advance;

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    always_comb begin
        b = r_in_data.data_byte;
        if (r_in_data.start_of_file) begin
            e_phase    = PH_HEADER;
            e_hdr_idx  = '0;
            e_id_left  = '0;
            e_rle      = 1'b0;
            e_grey     = 1'b0;
            e_width    = '0;
            e_height   = '0;
            e_pix_size = '0;
            e_pix_left = '0;
            e_pkt_left = '0;
            e_pkt_run  = 1'b0;
            e_asm      = '0;
            e_byte_idx = '0;
        end else begin
            e_phase    = r_phase;
            e_hdr_idx  = r_hdr_idx;
            e_id_left  = r_id_left;
            e_rle      = r_rle;
            e_grey     = r_grey;
            e_width    = r_width;
            e_height   = r_height;
            e_pix_size = r_pix_size;
            e_pix_left = r_pix_left;
            e_pkt_left = r_pkt_left;
            e_pkt_run  = r_pkt_run;
            e_asm      = r_asm;
            e_byte_idx = r_byte_idx;
        end

        n_phase    = e_phase;
        n_hdr_idx  = e_hdr_idx;
        n_id_left  = e_id_left;
        n_rle      = e_rle;
        n_grey     = e_grey;
        n_width    = e_width;
        n_height   = e_height;
        n_pix_size = e_pix_size;
        n_pix_left = e_pix_left;
        n_pkt_left = e_pkt_left;
        n_pkt_run  = e_pkt_run;
        n_asm      = e_asm;
        n_byte_idx = e_byte_idx;

        n_emit = 1'b0;
        n_out  = '0;

        area = 32'(e_width) * 32'(e_height);

        unique case (e_byte_idx)
            2'd0:    asm_next = e_asm | {24'd0, b};
            2'd1:    asm_next = e_asm | {16'd0, b, 8'd0};
            2'd2:    asm_next = e_asm | {8'd0, b, 16'd0};
            default: asm_next = e_asm | {b, 24'd0};
        endcase

        if (e_pix_size >= 3'd3) begin
            pix_val = {asm_next[31:24], asm_next[7:0], asm_next[15:8], asm_next[23:16]};
        end else begin
            pix_val = asm_next;
        end

        if (e_rle && e_pkt_run) begin
            if ({24'd0, e_pkt_left} < e_pix_left) begin
                run = e_pkt_left;
            end else begin
                run = e_pix_left[7:0];
            end
        end else begin
            run = 8'd1;
        end
        left_after = e_pix_left - 32'(run);

        if (!e_rle) begin
            pkt_after = e_pkt_left;
        end else if (e_pkt_run) begin
            pkt_after = '0;
        end else begin
            pkt_after = e_pkt_left - 8'd1;
        end

        unique case (e_phase)
            PH_HEADER: begin
                n_hdr_idx = e_hdr_idx + 5'd1;
                unique case (e_hdr_idx)
                    tga_pkg::HDR_ID_LEN: n_id_left = b;
                    tga_pkg::HDR_MAP_TYPE: begin
                        if (b == tga_pkg::MAP_PRESENT) begin
                            n_phase    = PH_ERROR;
                            n_emit     = 1'b1;
                            n_out.status = tga_pkg::ST_COLOR_MAP;
                        end
                    end
                    tga_pkg::HDR_IMG_TYPE: begin
                        priority if (b == tga_pkg::TYPE_TRUE_RAW) begin
                            n_rle = 1'b0; n_grey = 1'b0;
                        end else if (b == tga_pkg::TYPE_GREY_RAW) begin
                            n_rle = 1'b0; n_grey = 1'b1;
                        end else if (b == tga_pkg::TYPE_TRUE_RLE) begin
                            n_rle = 1'b1; n_grey = 1'b0;
                        end else if (b == tga_pkg::TYPE_GREY_RLE) begin
                            n_rle = 1'b1; n_grey = 1'b1;
                        end else begin
                            n_phase      = PH_ERROR;
                            n_emit       = 1'b1;
                            n_out.status = tga_pkg::ST_BAD_TYPE;
                        end
                    end
                    tga_pkg::HDR_WIDTH_LO:  n_width  = {e_width[15:8], b};
                    tga_pkg::HDR_WIDTH_HI:  n_width  = {b, e_width[7:0]};
                    tga_pkg::HDR_HEIGHT_LO: n_height = {e_height[15:8], b};
                    tga_pkg::HDR_HEIGHT_HI: n_height = {b, e_height[7:0]};
                    tga_pkg::HDR_DEPTH: begin
                        if (b != tga_pkg::DEPTH_8 && b != tga_pkg::DEPTH_16 &&
                            b != tga_pkg::DEPTH_24 && b != tga_pkg::DEPTH_32) begin
                            n_phase      = PH_ERROR;
                            n_emit       = 1'b1;
                            n_out.status = tga_pkg::ST_BAD_DEPTH;
                        end else begin
                            n_pix_size = b[5:3];
                        end
                    end
                    tga_pkg::HDR_DESC: begin
                        n_emit = 1'b1;
                        priority if (b[3:0] != tga_pkg::ALPHA_NONE &&
                                     b[3:0] != tga_pkg::ALPHA_EIGHT) begin
                            n_phase      = PH_ERROR;
                            n_out.status = tga_pkg::ST_BAD_ALPHA;
                        end else if (e_grey) begin
                            n_phase      = PH_ERROR;
                            n_out.status = tga_pkg::ST_GREYSCALE;
                        end else begin
                            n_pix_left = area;
                            if (e_id_left != 8'd0) begin
                                n_phase = PH_IDSKIP;
                            end else begin
                                n_byte_idx = '0;
                                n_asm      = '0;
                                n_pkt_left = '0;
                                if (area == 32'd0) begin
                                    n_phase = PH_DONE;
                                end else if (e_rle) begin
                                    n_phase = PH_PACKET;
                                end else begin
                                    n_phase = PH_PIXEL;
                                end
                            end
                            n_out.status          = tga_pkg::ST_HEADER_OK;
                            n_out.image_width     = e_width;
                            n_out.image_height    = e_height;
                            n_out.bytes_per_pixel = e_pix_size;
                            n_out.last_pixel      = (area == 32'd0);
                        end
                    end
                    default: ;
                endcase
            end
            PH_IDSKIP: begin
                n_id_left = e_id_left - 8'd1;
                if (e_id_left == 8'd1) begin
                    n_byte_idx = '0;
                    n_asm      = '0;
                    n_pkt_left = '0;
                    if (e_pix_left == 32'd0) begin
                        n_phase = PH_DONE;
                    end else if (e_rle) begin
                        n_phase = PH_PACKET;
                    end else begin
                        n_phase = PH_PIXEL;
                    end
                end
            end
            PH_PACKET: begin
                n_pkt_left = {1'b0, b[6:0]} + 8'd1;
                n_pkt_run  = b[7];
                n_byte_idx = '0;
                n_asm      = '0;
                n_phase    = PH_PIXEL;
            end
            PH_PIXEL: begin
                if ({1'b0, e_byte_idx} + 3'd1 < e_pix_size) begin
                    n_asm      = asm_next;
                    n_byte_idx = e_byte_idx + 2'd1;
                end else begin
                    n_pix_left = left_after;
                    n_pkt_left = pkt_after;
                    n_byte_idx = '0;
                    n_asm      = '0;
                    if (left_after == 32'd0) begin
                        n_phase = PH_DONE;
                    end else if (e_rle && pkt_after == 8'd0) begin
                        n_phase = PH_PACKET;
                    end
                    n_emit                = 1'b1;
                    n_out.status          = tga_pkg::ST_PIXEL_RUN;
                    n_out.pixel_value     = pix_val;
                    n_out.run_length      = run;
                    n_out.image_width     = e_width;
                    n_out.image_height    = e_height;
                    n_out.bytes_per_pixel = e_pix_size;
                    n_out.last_pixel      = (left_after == 32'd0);
                end
            end
            PH_DONE, PH_ERROR: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_HEADER;
            r_hdr_idx   <= '0;
            r_id_left   <= '0;
            r_rle       <= 1'b0;
            r_grey      <= 1'b0;
            r_width     <= '0;
            r_height    <= '0;
            r_pix_size  <= '0;
            r_pix_left  <= '0;
            r_pkt_left  <= '0;
            r_pkt_run   <= 1'b0;
            r_asm       <= '0;
            r_byte_idx  <= '0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_in.valid;
                r_in_data  <= i_in.data;
            end
            if (advance) begin
                r_phase    <= n_phase;
                r_hdr_idx  <= n_hdr_idx;
                r_id_left  <= n_id_left;
                r_rle      <= n_rle;
                r_grey     <= n_grey;
                r_width    <= n_width;
                r_height   <= n_height;
                r_pix_size <= n_pix_size;
                r_pix_left <= n_pix_left;
                r_pkt_left <= n_pkt_left;
                r_pkt_run  <= n_pkt_run;
                r_asm      <= n_asm;
                r_byte_idx <= n_byte_idx;
                r_out_valid <= n_emit;
                if (n_emit) begin
                    r_out_data <= n_out;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- sim/tga_rle_image_decoder_test.sv -----
// tga_rle_image_decoder_test: streams tga files byte by byte into the decoder and checks every
// status and pixel-run result against a cycle-free decoding model kept in the bench
// depends on tga_pkg, tga_in_if, tga_out_if and tga_rle_image_decoder

module tga_rle_image_decoder_test;

    localparam int CLK_PERIOD     = 20;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int DRAIN_CYCLES   = 2000;

    typedef enum logic [2:0] {
        DEC_HEADER, DEC_ID_SKIP, DEC_PACKET, DEC_PIXEL, DEC_DONE, DEC_ERROR
    } t_dec_phase;

    typedef struct {
        tga_pkg::t_in_item item;
        bit                hold;
    } t_feed_entry;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tga_in_if  in_ch ();
    tga_out_if out_ch ();

    tga_rle_image_decoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // decoding model state
    t_dec_phase  dec_phase;
    logic [4:0]  hdr_pos;
    logic [7:0]  id_left;
    logic        rle_on;
    logic        grey_on;
    logic [15:0] hdr_width;
    logic [15:0] hdr_height;
    logic [2:0]  pix_bytes;
    logic [31:0] pix_todo;
    logic [7:0]  pkt_left;
    logic        pkt_run;
    logic [31:0] pix_acc;
    logic [1:0]  pix_pos;

    t_feed_entry        feed_queue[$];
    tga_pkg::t_out_item awaited_results[$];

    logic in_accepted = 1'b0;
    bit   draining = 1'b0;
    bit   counting = 1'b1;
    int   hold_idle = 0;
    int   body_budget = 0;
    int   live_bytes = 0;
    int   files_queued = 0;
    int   bytes_accepted = 0;
    int   results_checked = 0;
    int   pixel_results = 0;
    int   header_results = 0;
    int   error_results = 0;
    int   mismatch_count = 0;

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    function automatic void clear_decoder();
        dec_phase  = DEC_HEADER;
        hdr_pos    = '0;
        id_left    = '0;
        rle_on     = 1'b0;
        grey_on    = 1'b0;
        hdr_width  = '0;
        hdr_height = '0;
        pix_bytes  = '0;
        pix_todo   = '0;
        pkt_left   = '0;
        pkt_run    = 1'b0;
        pix_acc    = '0;
        pix_pos    = '0;
    endfunction

    function automatic void push_error(input logic [2:0] code);
        tga_pkg::t_out_item r;
        r = '0;
        r.status = code;
        dec_phase = DEC_ERROR;
        awaited_results.push_back(r);
    endfunction

    function automatic void start_pixel_data();
        pix_pos  = '0;
        pix_acc  = '0;
        pkt_left = '0;
        if (pix_todo == 32'd0) dec_phase = DEC_DONE;
        else dec_phase = rle_on ? DEC_PACKET : DEC_PIXEL;
    endfunction

    task automatic decode_byte(input tga_pkg::t_in_item it);
        tga_pkg::t_out_item r;
        logic [7:0]  b;
        logic [4:0]  pos;
        logic [31:0] v;
        logic [31:0] run;
        b = it.data_byte;
        r = '0;
        if (it.start_of_file) clear_decoder();
        case (dec_phase)
            DEC_HEADER: begin
                pos = hdr_pos;
                hdr_pos = hdr_pos + 5'd1;
                case (pos)
                    tga_pkg::HDR_ID_LEN: id_left = b;
                    tga_pkg::HDR_MAP_TYPE:
                        if (b == tga_pkg::MAP_PRESENT) push_error(tga_pkg::ST_COLOR_MAP);
                    tga_pkg::HDR_IMG_TYPE: begin
                        if (b == tga_pkg::TYPE_TRUE_RAW) begin
                            rle_on = 1'b0; grey_on = 1'b0;
                        end else if (b == tga_pkg::TYPE_GREY_RAW) begin
                            rle_on = 1'b0; grey_on = 1'b1;
                        end else if (b == tga_pkg::TYPE_TRUE_RLE) begin
                            rle_on = 1'b1; grey_on = 1'b0;
                        end else if (b == tga_pkg::TYPE_GREY_RLE) begin
                            rle_on = 1'b1; grey_on = 1'b1;
                        end else begin
                            push_error(tga_pkg::ST_BAD_TYPE);
                        end
                    end
                    tga_pkg::HDR_WIDTH_LO: hdr_width[7:0] = b;
                    tga_pkg::HDR_WIDTH_HI: hdr_width[15:8] = b;
                    tga_pkg::HDR_HEIGHT_LO: hdr_height[7:0] = b;
                    tga_pkg::HDR_HEIGHT_HI: hdr_height[15:8] = b;
                    tga_pkg::HDR_DEPTH: begin
                        if (b != tga_pkg::DEPTH_8 && b != tga_pkg::DEPTH_16 &&
                            b != tga_pkg::DEPTH_24 && b != tga_pkg::DEPTH_32)
                            push_error(tga_pkg::ST_BAD_DEPTH);
                        else
                            pix_bytes = b[5:3];
                    end
                    tga_pkg::HDR_DESC: begin
                        if (b[3:0] != tga_pkg::ALPHA_NONE &&
                            b[3:0] != tga_pkg::ALPHA_EIGHT) begin
                            push_error(tga_pkg::ST_BAD_ALPHA);
                        end else if (grey_on) begin
                            push_error(tga_pkg::ST_GREYSCALE);
                        end else begin
                            pix_todo = {16'd0, hdr_width} * {16'd0, hdr_height};
                            if (id_left != 8'd0) dec_phase = DEC_ID_SKIP;
                            else start_pixel_data();
                            r.status = tga_pkg::ST_HEADER_OK;
                            r.image_width = hdr_width;
                            r.image_height = hdr_height;
                            r.bytes_per_pixel = pix_bytes;
                            r.last_pixel = (pix_todo == 32'd0);
                            awaited_results.push_back(r);
                        end
                    end
                    default: ;
                endcase
            end
            DEC_ID_SKIP: begin
                id_left = id_left - 8'd1;
                if (id_left == 8'd0) start_pixel_data();
            end
            DEC_PACKET: begin
                pkt_left = {1'b0, b[6:0]} + 8'd1;
                pkt_run = b[7];
                pix_pos = '0;
                pix_acc = '0;
                dec_phase = DEC_PIXEL;
            end
            DEC_PIXEL: begin
                pix_acc = pix_acc | ({24'd0, b} << (8 * pix_pos));
                if (int'(pix_pos) + 1 < int'(pix_bytes)) begin
                    pix_pos = pix_pos + 2'd1;
                end else begin
                    v = pix_acc;
                    // bgr to rgb
                    if (pix_bytes >= 3'd3) v = {v[31:24], v[7:0], v[15:8], v[23:16]};
                    run = 32'd1;
                    if (rle_on && pkt_run)
                        run = ({24'd0, pkt_left} < pix_todo) ? {24'd0, pkt_left} : pix_todo;
                    pix_todo = pix_todo - run;
                    if (rle_on) pkt_left = pkt_run ? 8'd0 : pkt_left - 8'd1;
                    pix_pos = '0;
                    pix_acc = '0;
                    if (pix_todo == 32'd0) dec_phase = DEC_DONE;
                    else if (rle_on && pkt_left == 8'd0) dec_phase = DEC_PACKET;
                    r.status = tga_pkg::ST_PIXEL_RUN;
                    r.pixel_value = v;
                    r.run_length = run[7:0];
                    r.image_width = hdr_width;
                    r.image_height = hdr_height;
                    r.bytes_per_pixel = pix_bytes;
                    r.last_pixel = (pix_todo == 32'd0);
                    awaited_results.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    function automatic bit no_idle();
        return bytes_accepted >= 400 && bytes_accepted < 600;
    endfunction

    // monitor: result check and prediction at the rising edge
    always @(posedge i_clk) begin : monitor
        tga_pkg::t_out_item want;
        in_accepted <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (awaited_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: expected no result actual %p", $time, out_ch.data);
                end else begin
                    want = awaited_results.pop_front();
                    results_checked++;
                    check_field("status", 32'(want.status), 32'(out_ch.data.status));
                    check_field("pixel_value", want.pixel_value, out_ch.data.pixel_value);
                    check_field("run_length", 32'(want.run_length),
                                32'(out_ch.data.run_length));
                    check_field("image_width", 32'(want.image_width),
                                32'(out_ch.data.image_width));
                    check_field("image_height", 32'(want.image_height),
                                32'(out_ch.data.image_height));
                    check_field("bytes_per_pixel", 32'(want.bytes_per_pixel),
                                32'(out_ch.data.bytes_per_pixel));
                    check_field("last_pixel", 32'(want.last_pixel),
                                32'(out_ch.data.last_pixel));
                    case (want.status)
                        tga_pkg::ST_PIXEL_RUN: pixel_results++;
                        tga_pkg::ST_HEADER_OK: header_results++;
                        default: error_results++;
                    endcase
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                decode_byte(in_ch.data);
                bytes_accepted++;
            end
        end
    end

    // driver: byte feed and result-side back pressure at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= draining || no_idle() || ($urandom_range(99) >= 33);
            if (in_accepted) feed_queue.pop_front();
            if (feed_queue.size() == 0) begin
                in_ch.valid <= 1'b0;
            end else if (feed_queue[0].hold) begin
                // hold off until every result is out
                in_ch.valid <= 1'b0;
                if (awaited_results.size() == 0) hold_idle++;
                else hold_idle = 0;
                if (hold_idle >= 6) begin
                    feed_queue.pop_front();
                    hold_idle = 0;
                end
            end else if (!(in_ch.valid && !in_accepted)) begin
                in_ch.valid <= no_idle() || ($urandom_range(99) >= 33);
                in_ch.data <= feed_queue[0].item;
            end
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic sof);
        t_feed_entry e;
        e.item.data_byte = b;
        e.item.start_of_file = sof;
        e.hold = 1'b0;
        feed_queue.push_back(e);
        if (counting) live_bytes++;
    endtask

    task automatic queue_hold();
        t_feed_entry e;
        e.item = '0;
        e.hold = 1'b1;
        feed_queue.push_back(e);
    endtask

    task automatic body_byte(input logic [7:0] b);
        if (body_budget > 0) begin
            queue_byte(b, 1'b0);
            body_budget--;
        end
    endtask

    task automatic queue_header(input logic [7:0] id_len, input logic [7:0] map_type,
                                input logic [7:0] img_type, input logic [15:0] w,
                                input logic [15:0] h, input logic [7:0] depth,
                                input logic [7:0] desc);
        files_queued++;
        queue_byte(id_len, 1'b1);
        queue_byte(map_type, 1'b0);
        queue_byte(img_type, 1'b0);
        for (int i = 3; i < 12; i++) queue_byte(8'($urandom_range(255)), 1'b0);
        queue_byte(w[7:0], 1'b0);
        queue_byte(w[15:8], 1'b0);
        queue_byte(h[7:0], 1'b0);
        queue_byte(h[15:8], 1'b0);
        queue_byte(depth, 1'b0);
        queue_byte(desc, 1'b0);
        for (int i = 0; i < int'(id_len); i++) queue_byte(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic queue_body(input bit rle, input int npix, input int bpp);
        int         left;
        int         cnt;
        int         used;
        logic [7:0] pkt;
        if (!rle) begin
            for (int i = 0; i < npix * bpp; i++) body_byte(8'($urandom_range(255)));
        end else begin
            left = npix;
            while (left > 0) begin
                cnt = ($urandom_range(9) == 0) ? $urandom_range(128, 1) : $urandom_range(4, 1);
                pkt = 8'(cnt - 1);
                pkt[7] = 1'($urandom_range(1));
                body_byte(pkt);
                used = pkt[7] ? 1 : (cnt < left ? cnt : left);
                for (int i = 0; i < used * bpp; i++) body_byte(8'($urandom_range(255)));
                left = (cnt < left) ? left - cnt : 0;
            end
        end
    endtask

    task automatic queue_good_file();
        bit          rle;
        int          bpp;
        int          sel;
        logic [7:0]  map_type;
        logic [7:0]  id_len;
        logic [7:0]  desc;
        logic [15:0] w;
        logic [15:0] h;
        rle = 1'($urandom_range(1));
        bpp = $urandom_range(4, 1);
        desc = 8'(($urandom_range(15) << 4) |
                  ($urandom_range(1) ? tga_pkg::ALPHA_EIGHT : tga_pkg::ALPHA_NONE));
        map_type = 8'd0;
        if ($urandom_range(4) == 0) begin
            map_type = 8'($urandom_range(255));
            if (map_type == tga_pkg::MAP_PRESENT) map_type = 8'd0;
        end
        sel = $urandom_range(99);
        if (sel < 85) id_len = 8'($urandom_range(3));
        else if (sel < 97) id_len = 8'($urandom_range(20, 4));
        else id_len = 8'd255;
        sel = $urandom_range(99);
        if (sel < 80) begin
            w = 16'($urandom_range(4, 1));
            h = 16'($urandom_range(4, 1));
        end else if (sel < 95) begin
            w = 16'($urandom_range(40, 5));
            h = 16'($urandom_range(2, 1));
        end else if (sel < 98) begin
            w = 16'd0;
            h = 16'($urandom_range(65535));
        end else begin
            w = 16'($urandom_range(65535));
            h = 16'd0;
        end
        if (w == 16'd0 || h == 16'd0) body_budget = 0;
        else if ($urandom_range(11) == 0) body_budget = $urandom_range(int'(w) * int'(h) * bpp);
        else body_budget = 32'h7fff_ffff;
        queue_header(id_len, map_type, rle ? tga_pkg::TYPE_TRUE_RLE : tga_pkg::TYPE_TRUE_RAW,
                     w, h, 8'(bpp * 8), desc);
        queue_body(rle, int'(w) * int'(h), bpp);
        if (body_budget > 0 && $urandom_range(5) == 0) begin
            // bytes past the end of the image
            counting = 1'b0;
            for (int i = 0; i < $urandom_range(5, 1); i++)
                queue_byte(8'($urandom_range(255)), 1'b0);
            counting = 1'b1;
        end
    endtask

    task automatic queue_bad_file();
        logic [7:0] img_type;
        logic [7:0] depth;
        logic [7:0] desc;
        logic [7:0] map_type;
        int         kind;
        counting = 1'b0;
        img_type = $urandom_range(1) ? tga_pkg::TYPE_TRUE_RLE : tga_pkg::TYPE_TRUE_RAW;
        depth = $urandom_range(1) ? tga_pkg::DEPTH_24 : tga_pkg::DEPTH_32;
        desc = {4'd0, $urandom_range(1) ? tga_pkg::ALPHA_EIGHT : tga_pkg::ALPHA_NONE};
        map_type = 8'd0;
        kind = $urandom_range(4);
        case (kind)
            0: map_type = tga_pkg::MAP_PRESENT;
            1: begin
                do img_type = 8'($urandom_range(255));
                while (img_type == tga_pkg::TYPE_TRUE_RAW || img_type == tga_pkg::TYPE_GREY_RAW ||
                       img_type == tga_pkg::TYPE_TRUE_RLE || img_type == tga_pkg::TYPE_GREY_RLE);
            end
            2: begin
                do depth = 8'($urandom_range(255));
                while (depth == tga_pkg::DEPTH_8 || depth == tga_pkg::DEPTH_16 ||
                       depth == tga_pkg::DEPTH_24 || depth == tga_pkg::DEPTH_32);
            end
            3: begin
                do desc[3:0] = 4'($urandom_range(15));
                while (desc[3:0] == tga_pkg::ALPHA_NONE || desc[3:0] == tga_pkg::ALPHA_EIGHT);
            end
            default: img_type = $urandom_range(1) ? tga_pkg::TYPE_GREY_RLE
                                                  : tga_pkg::TYPE_GREY_RAW;
        endcase
        queue_header(8'($urandom_range(3)), map_type, img_type, 16'($urandom_range(4, 1)),
                     16'($urandom_range(4, 1)), depth, desc);
        counting = 1'b1;
    endtask

    task automatic queue_noise();
        counting = 1'b0;
        files_queued++;
        queue_byte(8'($urandom_range(255)), 1'b1);
        for (int i = 0; i < $urandom_range(20, 1); i++)
            queue_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
        counting = 1'b1;
    endtask

    initial begin : run_control
        int sel;
        int drain;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        clear_decoder();

        // header errors, each kind at least once
        queue_header(8'd0, tga_pkg::MAP_PRESENT, tga_pkg::TYPE_TRUE_RAW, 16'd1, 16'd1,
                     tga_pkg::DEPTH_8, 8'd0);
        queue_header(8'd0, 8'd0, 8'd9, 16'd1, 16'd1, tga_pkg::DEPTH_8, 8'd0);
        queue_header(8'd0, 8'd0, tga_pkg::TYPE_TRUE_RAW, 16'd1, 16'd1, 8'd15, 8'd0);
        queue_header(8'd0, 8'd0, tga_pkg::TYPE_TRUE_RLE, 16'd1, 16'd1, tga_pkg::DEPTH_24,
                     8'h03);
        queue_header(8'd0, 8'd0, tga_pkg::TYPE_GREY_RAW, 16'd1, 16'd1, tga_pkg::DEPTH_8,
                     8'd0);
        queue_header(8'd1, 8'd0, tga_pkg::TYPE_GREY_RLE, 16'd1, 16'd1, tga_pkg::DEPTH_8,
                     8'h08);
        // empty images at the dimension extremes, then ignored bytes
        queue_header(8'd0, 8'd0, tga_pkg::TYPE_TRUE_RAW, 16'hffff, 16'd0, tga_pkg::DEPTH_32,
                     8'd0);
        queue_byte(8'hff, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_header(8'd255, 8'd0, tga_pkg::TYPE_TRUE_RLE, 16'd0, 16'hffff,
                     tga_pkg::DEPTH_16, 8'h08);
        // raw 32-bit pixel after an id field, map type other than present
        queue_header(8'd2, 8'hff, tga_pkg::TYPE_TRUE_RAW, 16'd1, 16'd1, tga_pkg::DEPTH_32,
                     8'hf8);
        queue_byte(8'hff, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h01, 1'b0);
        // run packet longer than the image
        queue_header(8'd0, 8'd0, tga_pkg::TYPE_TRUE_RLE, 16'd3, 16'd1, tga_pkg::DEPTH_24,
                     8'd0);
        queue_byte(8'hff, 1'b0);
        for (int i = 0; i < 3; i++) queue_byte(8'($urandom_range(255)), 1'b0);
        // raw packet longer than the image, trailing bytes ignored
        queue_header(8'd0, 8'd0, tga_pkg::TYPE_TRUE_RLE, 16'd2, 16'd2, tga_pkg::DEPTH_16,
                     8'd0);
        queue_byte(8'h7f, 1'b0);
        for (int i = 0; i < 10; i++) queue_byte(8'($urandom_range(255)), 1'b0);
        // file cut short by a new start of file
        queue_header(8'd0, 8'd0, tga_pkg::TYPE_TRUE_RAW, 16'd2, 16'd1, tga_pkg::DEPTH_8,
                     8'd0);
        queue_byte(8'h5a, 1'b0);
        // run then raw packet on 8-bit pixels
        queue_header(8'd0, 8'd0, tga_pkg::TYPE_TRUE_RLE, 16'd1, 16'd2, tga_pkg::DEPTH_8,
                     8'd0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hff, 1'b0);
        queue_hold();

        while (live_bytes < 750) begin
            sel = $urandom_range(99);
            if (sel < 75) queue_good_file();
            else if (sel < 90) queue_bad_file();
            else queue_noise();
            if ($urandom_range(29) == 0) queue_hold();
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (feed_queue.size() != 0) @(posedge i_clk);
        draining = 1'b1;
        drain = 0;
        while (awaited_results.size() != 0 && drain < DRAIN_CYCLES) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (10) @(posedge i_clk);
        if (awaited_results.size() != 0) begin
            mismatch_count += awaited_results.size();
            $display("%0t: %0d results never arrived", $time, awaited_results.size());
        end

        $display("%0d files, %0d bytes transferred, %0d results checked",
                 files_queued, bytes_accepted, results_checked);
        $display("%0d pixel runs, %0d headers accepted, %0d headers refused",
                 pixel_results, header_results, error_results);
        if (mismatch_count == 0) begin
            $display("tga_rle_image_decoder_test OK");
        end else begin
            $display("tga_rle_image_decoder_test NOT OK");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("%0t: timeout", $time);
        $display("tga_rle_image_decoder_test NOT OK");
        $finish;
    end

endmodule
